@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the barycentric evaluator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside of reset.
`define TBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tbe assertion failed");

// Check that cons holds in the cycle after ante.
`define TBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbe assertion failed");

`endif

@@ rtl/core/tbe_pkg.sv @@
// Types, constants and helper functions for the barycentric evaluator.
// Used by every module of the block; depends on nothing.
package tbe_pkg;

    localparam int TBE_QUEUE_DEPTH = 4;
    localparam int TBE_U_W         = 51;   // unsigned dividend width
    localparam int TBE_M_W         = 35;   // divisor width (four times the area)

    localparam logic [2:0] CFG_A_X = 3'd0;
    localparam logic [2:0] CFG_A_Y = 3'd1;
    localparam logic [2:0] CFG_B_X = 3'd2;
    localparam logic [2:0] CFG_B_Y = 3'd3;
    localparam logic [2:0] CFG_C_X = 3'd4;
    localparam logic [2:0] CFG_C_Y = 3'd5;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] attr_at_a;
        logic signed [15:0] attr_at_b;
        logic signed [15:0] attr_at_c;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] weight_a;
        logic signed [19:0] weight_b;
        logic signed [19:0] weight_c;
        logic               inside_res;
        logic               degenerate;
        logic signed [15:0] interp_value;
    } t_out_item;

    // One classified item, handed from the front to the back.
    typedef struct packed {
        logic [TBE_U_W-1:0] u_a;
        logic               neg_a;
        logic [TBE_U_W-1:0] u_b;
        logic               neg_b;
        logic [TBE_M_W-1:0] m;
        logic               degen;
        logic signed [15:0] attr_a;
        logic signed [15:0] attr_b;
        logic signed [15:0] attr_c;
    } t_work;

    function automatic logic signed [19:0] sat_w(input logic signed [53:0] v);
        logic signed [19:0] r;
        begin
            if (v > 54'sd524287) begin
                r = 20'sd524287;
            end else if (v < -54'sd524288) begin
                r = -20'sd524288;
            end else begin
                r = v[19:0];
            end
            return r;
        end
    endfunction

    function automatic logic signed [15:0] sat_i(input logic signed [21:0] v);
        logic signed [15:0] r;
        begin
            if (v > 22'sd32767) begin
                r = 16'sd32767;
            end else if (v < -22'sd32768) begin
                r = -16'sd32768;
            end else begin
                r = v[15:0];
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/core/tbe_front.sv @@
// Front end: vertex registers, edge products and sign normalization.
// Uses tbe_pkg; feeds tbe_queue with t_work beats.
module tbe_front import tbe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_push,
    output t_work       o_work,
    input  logic        i_full
);
    logic signed [15:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic en;

    logic               r_s1_valid;
    logic signed [16:0] r_dx, r_dy, r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [15:0] r_s1_va, r_s1_vb, r_s1_vc;

    logic               r_s2_valid;
    logic signed [33:0] r_p_na1, r_p_na2, r_p_nb1, r_p_nb2, r_p_d1, r_p_d2;
    logic signed [15:0] r_s2_va, r_s2_vb, r_s2_vc;

    logic signed [34:0] na, nb, d, nan, nbn, den;
    logic signed [51:0] num_a, num_b;
    logic               neg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0;
            r_by <= '0; r_cx <= '0; r_cy <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A_X: r_ax <= i_cfg_data;
                CFG_A_Y: r_ay <= i_cfg_data;
                CFG_B_X: r_bx <= i_cfg_data;
                CFG_B_Y: r_by <= i_cfg_data;
                CFG_C_X: r_cx <= i_cfg_data;
                CFG_C_Y: r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the whole front while the last stage waits on a full queue.
    assign en         = !(r_s2_valid && i_full);
    assign o_in_stall = !en;
    assign o_push     = r_s2_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx    <= 17'(i_in_item.point_x) - 17'(r_cx);
            r_dy    <= 17'(i_in_item.point_y) - 17'(r_cy);
            r_e1x   <= 17'(r_by) - 17'(r_cy);
            r_e1y   <= 17'(r_cx) - 17'(r_bx);
            r_e2x   <= 17'(r_cy) - 17'(r_ay);
            r_e2y   <= 17'(r_ax) - 17'(r_cx);
            r_s1_va <= i_in_item.attr_at_a;
            r_s1_vb <= i_in_item.attr_at_b;
            r_s1_vc <= i_in_item.attr_at_c;

            r_p_na1 <= r_dx * r_e1x;
            r_p_na2 <= r_dy * r_e1y;
            r_p_nb1 <= r_dx * r_e2x;
            r_p_nb2 <= r_dy * r_e2y;
            r_p_d1  <= r_e1x * r_e2y;
            r_p_d2  <= r_e1y * r_e2x;
            r_s2_va <= r_s1_va;
            r_s2_vb <= r_s1_vb;
            r_s2_vc <= r_s1_vc;
        end
    end

    always_comb begin
        na  = 35'(r_p_na1) + 35'(r_p_na2);
        nb  = 35'(r_p_nb1) + 35'(r_p_nb2);
        d   = 35'(r_p_d1) - 35'(r_p_d2);
        neg = d[34];
        den = neg ? -d : d;
        nan = neg ? -na : na;
        nbn = neg ? -nb : nb;
        // round(n * 2^16 / den) = floor((2^17 n + den) / (2 den))
        num_a = $signed({nan, 17'd0}) + $signed({17'd0, den});
        num_b = $signed({nbn, 17'd0}) + $signed({17'd0, den});

        o_work.u_a    = num_a[51] ? ~num_a[50:0] : num_a[50:0];
        o_work.neg_a  = num_a[51];
        o_work.u_b    = num_b[51] ? ~num_b[50:0] : num_b[50:0];
        o_work.neg_b  = num_b[51];
        o_work.m      = {den[33:0], 1'b0};
        o_work.degen  = (d == '0);
        o_work.attr_a = r_s2_va;
        o_work.attr_b = r_s2_vb;
        o_work.attr_c = r_s2_vc;
    end

endmodule

@@ rtl/core/tbe_queue.sv @@
// Small register FIFO of t_work beats between the front and the back.
// Uses tbe_pkg; depth set by the top-level parameter.
`include "assert_macros.svh"
module tbe_queue import tbe_pkg::*; #(
    parameter int DEPTH = TBE_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_work o_work
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    `TBE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))

endmodule

@@ rtl/core/tbe_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
// Uses tbe_pkg widths; instantiated by tbe_back.
module tbe_div import tbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [TBE_U_W-1:0] i_u,
    input  logic [TBE_M_W-1:0] i_m,
    output logic [TBE_U_W-1:0] o_q
);
    logic [TBE_M_W-1:0] r_rem  [TBE_U_W];
    logic [TBE_U_W-1:0] r_word [TBE_U_W];
    logic [TBE_M_W-1:0] r_m    [TBE_U_W];

    genvar g;
    generate
        for (g = 0; g < TBE_U_W; g++) begin : g_stage
            logic [TBE_M_W-1:0] rem_in, m_in;
            logic [TBE_U_W-1:0] word_in;
            logic [TBE_M_W:0]   trial;
            logic               ge;
            if (g == 0) begin : g_first
                assign rem_in  = '0;
                assign word_in = i_u;
                assign m_in    = i_m;
            end else begin : g_next
                assign rem_in  = r_rem[g-1];
                assign word_in = r_word[g-1];
                assign m_in    = r_m[g-1];
            end
            // Shift in the next dividend bit, subtract if it fits.
            assign trial = {rem_in, word_in[TBE_U_W-1]};
            assign ge    = (trial >= {1'b0, m_in});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g]  <= ge ? TBE_M_W'(trial - {1'b0, m_in}) : trial[TBE_M_W-1:0];
                    r_word[g] <= {word_in[TBE_U_W-2:0], ge};
                    r_m[g]    <= m_in;
                end
            end
        end
    endgenerate

    assign o_q = r_word[TBE_U_W-1];

endmodule

@@ rtl/core/tbe_back.sv @@
// Back end: two divider pipes, weight rounding and saturation, interpolation.
// Uses tbe_pkg and tbe_div; pops t_work beats from tbe_queue.
`include "assert_macros.svh"
module tbe_back import tbe_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_work     i_work,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);
    localparam int NS = TBE_U_W;

    logic en;
    logic [TBE_U_W-1:0] q_a, q_b;

    logic               r_sv    [NS];
    logic               r_sna   [NS];
    logic               r_snb   [NS];
    logic               r_sdg   [NS];
    logic signed [15:0] r_sva   [NS];
    logic signed [15:0] r_svb   [NS];
    logic signed [15:0] r_svc   [NS];

    logic               r_f1_valid, r_f1_inside, r_f1_degen;
    logic signed [19:0] r_f1_wa, r_f1_wb, r_f1_wc;
    logic signed [15:0] r_f1_va, r_f1_vb, r_f1_vc;

    logic               r_f2_valid, r_f2_inside, r_f2_degen;
    logic signed [19:0] r_f2_wa, r_f2_wb, r_f2_wc;
    logic signed [35:0] r_pa, r_pb, r_pc;

    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [51:0] ra, rb;
    logic signed [53:0] rc;
    logic signed [19:0] wa, wb, wc;
    logic signed [37:0] sum;

    // Freeze the back while a finished beat waits at the output.
    assign en          = !(r_out_valid && i_out_stall);
    assign o_pop       = en && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    tbe_div u_div_a (.i_clk(i_clk), .i_en(en), .i_u(i_work.u_a), .i_m(i_work.m), .o_q(q_a));
    tbe_div u_div_b (.i_clk(i_clk), .i_en(en), .i_u(i_work.u_b), .i_m(i_work.m), .o_q(q_b));

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[g] <= 1'b0;
                end else if (en) begin
                    r_sv[g] <= (g == 0) ? !i_empty : r_sv[(g == 0) ? 0 : g - 1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (g == 0) begin
                        r_sna[g] <= i_work.neg_a;
                        r_snb[g] <= i_work.neg_b;
                        r_sdg[g] <= i_work.degen;
                        r_sva[g] <= i_work.attr_a;
                        r_svb[g] <= i_work.attr_b;
                        r_svc[g] <= i_work.attr_c;
                    end else begin
                        r_sna[g] <= r_sna[(g == 0) ? 0 : g - 1];
                        r_snb[g] <= r_snb[(g == 0) ? 0 : g - 1];
                        r_sdg[g] <= r_sdg[(g == 0) ? 0 : g - 1];
                        r_sva[g] <= r_sva[(g == 0) ? 0 : g - 1];
                        r_svb[g] <= r_svb[(g == 0) ? 0 : g - 1];
                        r_svc[g] <= r_svc[(g == 0) ? 0 : g - 1];
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        // Undo the floor trick for negative numerators: q = ~(~n / m).
        ra  = r_sna[NS-1] ? $signed(~{1'b0, q_a}) : $signed({1'b0, q_a});
        rb  = r_snb[NS-1] ? $signed(~{1'b0, q_b}) : $signed({1'b0, q_b});
        rc  = 54'sd65536 - 54'(ra) - 54'(rb);
        wa  = sat_w(54'(ra));
        wb  = sat_w(54'(rb));
        wc  = sat_w(rc);
        sum = 38'(r_pa) + 38'(r_pb) + 38'(r_pc) + 38'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid  <= 1'b0;
            r_f2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_f1_valid  <= r_sv[NS-1];
            r_f2_valid  <= r_f1_valid;
            r_out_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_degen  <= r_sdg[NS-1];
            r_f1_wa     <= r_sdg[NS-1] ? '0 : wa;
            r_f1_wb     <= r_sdg[NS-1] ? '0 : wb;
            r_f1_wc     <= r_sdg[NS-1] ? '0 : wc;
            r_f1_inside <= !r_sdg[NS-1] && !wa[19] && !wb[19] && !wc[19];
            r_f1_va     <= r_sva[NS-1];
            r_f1_vb     <= r_svb[NS-1];
            r_f1_vc     <= r_svc[NS-1];

            r_pa        <= r_f1_wa * r_f1_va;
            r_pb        <= r_f1_wb * r_f1_vb;
            r_pc        <= r_f1_wc * r_f1_vc;
            r_f2_wa     <= r_f1_wa;
            r_f2_wb     <= r_f1_wb;
            r_f2_wc     <= r_f1_wc;
            r_f2_inside <= r_f1_inside;
            r_f2_degen  <= r_f1_degen;

            r_out.weight_a     <= r_f2_wa;
            r_out.weight_b     <= r_f2_wb;
            r_out.weight_c     <= r_f2_wc;
            r_out.inside_res   <= r_f2_inside;
            r_out.degenerate   <= r_f2_degen;
            r_out.interp_value <= sat_i(sum[37:16]);
        end
    end

    `TBE_ASSERT(a_degen_zero, i_clk, i_rst_n, r_out_valid && r_out.degenerate |-> r_out.weight_a == '0 && r_out.weight_c == '0 && !r_out.inside_res)
    `TBE_ASSERT(a_inside_sign, i_clk, i_rst_n, r_out_valid && r_out.inside_res |-> !r_out.weight_a[19] && !r_out.weight_b[19] && !r_out.weight_c[19])
    `TBE_ASSERT_NEXT(a_pop_enters, i_clk, i_rst_n, o_pop, r_sv[0])

endmodule

@@ rtl/core/triangle_barycentric_evaluator_top.sv @@
// Barycentric evaluator for one configured screen triangle. Each input beat
// (point, three vertex attributes) gives one output beat with the Q3.16
// weights, the inside and degenerate flags and the interpolated attribute.
// One beat is taken per clock while o_in_stall is low. A beat passes two front
// stages for the edge products, the queue register, 51 stages of the bit-per-stage
// divider that forms each weight, and three stages for rounding, the attribute
// products and the output register. Write the vertex registers only while idle.
module triangle_barycentric_evaluator_top import tbe_pkg::*; #(
    parameter int QUEUE_DEPTH = TBE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item
);
    logic  push, full, pop, empty;
    t_work work_in, work_out;

    tbe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_push(push), .o_work(work_in), .i_full(full)
    );

    tbe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_work(work_in), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_work(work_out)
    );

    tbe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_work(work_out), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item)
    );

endmodule

@@ verif/triangle_barycentric_evaluator_top_tb.sv @@
// Testbench for the triangle barycentric evaluator: drives point beats under
// several idle and stall patterns and checks every output beat against an
// in-bench weight and interpolation predictor. Depends on tbe_pkg and the top.
module triangle_barycentric_evaluator_top_tb;
    import tbe_pkg::*;

    class bary_scoreboard;
        t_out_item pending_results[$];
        int mismatches;
        int results_seen;
        logic signed [15:0] vtx[6];

        function new();
            mismatches = 0;
            results_seen = 0;
            foreach (vtx[k]) vtx[k] = '0;
        endfunction

        function automatic longint floor_quot(longint a, longint d);
            longint q;
            q = a / d;
            if ((a % d) != 0 && ((a < 0) != (d < 0))) q = q - 1;
            return q;
        endfunction

        function automatic longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function automatic t_out_item weigh_point(t_in_item it);
            t_out_item r;
            longint ax, ay, bx, by, cx, cy, dx, dy, den, na, nb, ra, rb, rc;
            longint wa, wb, wc, sum;
            ax = vtx[CFG_A_X]; ay = vtx[CFG_A_Y];
            bx = vtx[CFG_B_X]; by = vtx[CFG_B_Y];
            cx = vtx[CFG_C_X]; cy = vtx[CFG_C_Y];
            r = '0;
            den = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
            if (den == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            dx = longint'(it.point_x) - cx;
            dy = longint'(it.point_y) - cy;
            na = dx * (by - cy) + dy * (cx - bx);
            nb = dx * (cy - ay) + dy * (ax - cx);
            if (den < 0) begin
                den = -den; na = -na; nb = -nb;
            end
            ra = floor_quot(2 * na * 65536 + den, 2 * den);
            rb = floor_quot(2 * nb * 65536 + den, 2 * den);
            rc = 65536 - ra - rb;
            wa = clip(ra, -524288, 524287);
            wb = clip(rb, -524288, 524287);
            wc = clip(rc, -524288, 524287);
            r.weight_a = wa[19:0];
            r.weight_b = wb[19:0];
            r.weight_c = wc[19:0];
            r.inside_res = (wa >= 0 && wb >= 0 && wc >= 0);
            sum = wa * longint'(it.attr_at_a) + wb * longint'(it.attr_at_b)
                + wc * longint'(it.attr_at_c);
            sum = clip(floor_quot(sum + 32768, 65536), -32768, 32767);
            r.interp_value = sum[15:0];
            return r;
        endfunction

        function void note_point(t_in_item it);
            pending_results.push_back(weigh_point(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_r;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat %p", got);
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.weight_a !== exp_r.weight_a || got.weight_b !== exp_r.weight_b ||
                got.weight_c !== exp_r.weight_c || got.inside_res !== exp_r.inside_res ||
                got.degenerate !== exp_r.degenerate ||
                got.interp_value !== exp_r.interp_value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch #%0d: expected %p, got %p", mismatches, exp_r, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;

    bary_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int idle_cycles;
    int points_sent;
    int triangles_used;

    triangle_barycentric_evaluator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        points_sent = 0;
        triangles_used = 0;
    end

    // Receiver: random stall, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall && i_rst_n) board.check_result(o_out_item);
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat moving on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || hold_off_cycles > 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("timeout with %0d results pending", board.pending_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Leave valid high so writes can follow back to back; the caller drops it.
    task automatic write_vertex(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx <= CFG_C_Y) board.vtx[idx] = val;
    endtask

    task automatic load_triangle(input logic [15:0] v[6]);
        for (int k = 0; k < 6; k++) write_vertex(k[2:0], v[k]);
        // unused index must be ignored
        write_vertex(3'd6 + 3'($urandom_range(1)), 16'($urandom));
        i_cfg_valid <= 1'b0;
        triangles_used++;
    endtask

    // Drain all expected beats, then let the pipeline settle.
    task automatic drain_idle();
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_point(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_point(it);
        points_sent++;
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    function automatic logic [15:0] coord_near(int range);
        int v;
        v = $urandom_range(2 * range) - range;
        return v[15:0];
    endfunction

    // Mostly points inside or near the triangle's box, some anywhere.
    function automatic t_in_item random_point();
        t_in_item it;
        int lo_x, hi_x, lo_y, hi_y, s;
        it.attr_at_a = 16'($urandom);
        it.attr_at_b = 16'($urandom);
        it.attr_at_c = 16'($urandom);
        if ($urandom_range(3) == 0) begin
            it.point_x = 16'($urandom);
            it.point_y = 16'($urandom);
        end else begin
            lo_x = board.vtx[CFG_A_X]; hi_x = lo_x;
            lo_y = board.vtx[CFG_A_Y]; hi_y = lo_y;
            for (int k = 2; k < 6; k += 2) begin
                if (board.vtx[k] < lo_x) lo_x = board.vtx[k];
                if (board.vtx[k] > hi_x) hi_x = board.vtx[k];
                if (board.vtx[k+1] < lo_y) lo_y = board.vtx[k+1];
                if (board.vtx[k+1] > hi_y) hi_y = board.vtx[k+1];
            end
            s = lo_x + int'($urandom_range(hi_x - lo_x));
            it.point_x = s[15:0];
            s = lo_y + int'($urandom_range(hi_y - lo_y));
            it.point_y = s[15:0];
        end
        if ($urandom_range(7) == 0) begin
            it.attr_at_a = $urandom_range(1) ? 16'h7fff : 16'h8000;
            it.attr_at_b = it.attr_at_a;
            it.attr_at_c = it.attr_at_a;
        end
        return it;
    endfunction

    function automatic t_in_item make_point(logic [15:0] px, logic [15:0] py,
                                            logic [15:0] va, logic [15:0] vb,
                                            logic [15:0] vc);
        t_in_item it;
        it.point_x = px; it.point_y = py;
        it.attr_at_a = va; it.attr_at_b = vb; it.attr_at_c = vc;
        return it;
    endfunction

    initial begin
        logic [15:0] tri_v[6];
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset triangle is degenerate
        send_point(make_point(16'h1234, 16'h8000, 16'h7fff, 16'h8000, 16'h0001));
        send_point(make_point(16'hffff, 16'h7fff, 16'h0000, 16'hffff, 16'h7fff));
        end_burst();
        drain_idle();

        // counterclockwise triangle: vertices, midpoint, far and extreme points
        tri_v = '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100};
        load_triangle(tri_v);
        send_point(make_point(16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0000));
        send_point(make_point(16'h0100, 16'h0000, 16'h7fff, 16'h8000, 16'h0000));
        send_point(make_point(16'h0000, 16'h0100, 16'h7fff, 16'h8000, 16'h1234));
        send_point(make_point(16'h0055, 16'h0055, 16'h7fff, 16'h7fff, 16'h7fff));
        send_point(make_point(16'h0080, 16'h0080, 16'h8000, 16'h8000, 16'h8000));
        send_point(make_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff));
        send_point(make_point(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000));
        send_point(make_point(16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h5555));
        send_point(make_point(16'hfffd, 16'h0001, 16'haaaa, 16'h5555, 16'hffff));
        end_burst();
        drain_idle();

        // clockwise triangle with extreme vertices
        tri_v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000};
        load_triangle(tri_v);
        send_point(make_point(16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h0100));
        send_point(make_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
        send_point(make_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_point(make_point(16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000));
        end_burst();
        drain_idle();

        // collinear, nonzero vertices: degenerate again
        tri_v = '{16'h0010, 16'h0020, 16'h0020, 16'h0040, 16'hfff0, 16'hffe0};
        load_triangle(tri_v);
        send_point(make_point(16'h0011, 16'h0022, 16'h7fff, 16'h7fff, 16'h7fff));
        send_point(make_point(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000));
        end_burst();
        drain_idle();

        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (phase == 7) begin
                for (int k = 0; k < 6; k++) tri_v[k] = $urandom_range(1) ? 16'h7fff : 16'h8000;
            end else if (phase == 6) begin
                for (int k = 0; k < 6; k++) tri_v[k] = 16'($urandom);
            end else begin
                for (int k = 0; k < 6; k++) tri_v[k] = coord_near(1 << (4 + phase));
            end
            load_triangle(tri_v);
            if (phase == 2) hold_off_cycles = 300;
            for (int n = 0; n < 115; n++) send_point(random_point());
            end_burst();
            drain_idle();
        end

        $display("%0d points over %0d triangles, %0d results checked, %0d mismatches",
                 points_sent, triangles_used, board.results_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
